// ----- rtl/smh_pkg.sv -----
`timescale 1ns / 1ps
// smh_pkg: constants, types and the hash term function for the sorted multiset
// used by smh_cell and sorted_multiset_with_hash; depends on nothing

package smh_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int HASH_SHIFT = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_HASH = 1'b1
    } t_state;

    typedef struct packed {
        logic              load;
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_cmd;

    // x * (1 + 1<<5)^i, carry-less, as x times the product of (1 + 1<<(5*2^b)) over the set bits of i
    function automatic logic [DATA_W-1:0] hash_term(input logic [DATA_W-1:0] x,
                                                     input logic [IDX_W-1:0]  idx);
        logic [DATA_W-1:0] t;
        t = x;
        for (int b = 0; b < IDX_W; b++) begin
            if (idx[b]) begin
                t = t ^ (t << (HASH_SHIFT << b));
            end
        end
        return t;
    endfunction

endpackage

// ----- rtl/smh_cell.sv -----
`timescale 1ns / 1ps
// smh_cell: one slot of the sorted store, shifts left or right with its neighbors
// depends on smh_pkg

module smh_cell (
    input  logic                       i_clk,
    input  smh_pkg::t_cmd              i_cmd,
    input  logic [smh_pkg::IDX_W-1:0]  i_index,
    input  logic                       i_valid,
    input  logic [smh_pkg::DATA_W-1:0] i_left_entry,
    input  logic [smh_pkg::DATA_W-1:0] i_right_entry,
    input  logic                       i_left_ge,
    input  logic                       i_found_in,
    output logic [smh_pkg::DATA_W-1:0] o_entry,
    output logic                       o_ge,
    output logic                       o_found_out,
    output logic [smh_pkg::DATA_W-1:0] o_term
);

    logic [smh_pkg::DATA_W-1:0] r_entry;
    logic [smh_pkg::DATA_W-1:0] n_entry;
    logic                       w_eq;

    assign o_ge        = i_valid && ($signed(r_entry) >= $signed(i_cmd.value));
    assign w_eq        = i_valid && (r_entry == i_cmd.value);
    assign o_found_out = i_found_in || w_eq;
    assign o_entry     = r_entry;
    assign o_term      = i_valid ? smh_pkg::hash_term(r_entry, i_index) : '0;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.load) begin
            case (i_cmd.op)
                smh_pkg::OP_INSERT: begin
                    if (i_left_ge) begin
                        n_entry = i_left_entry;
                    end else if (o_ge || !i_valid) begin
                        n_entry = i_cmd.value;
                    end
                end
                smh_pkg::OP_REMOVE: begin
                    if (o_found_out) begin
                        n_entry = i_right_entry;
                    end
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/sorted_multiset_with_hash.sv -----
`timescale 1ns / 1ps
// sorted_multiset_with_hash: sorted multiset store as a chain of smh_cell slots
// with count, status and an xor-shift hash of the entries; depends on smh_pkg, smh_cell
//
//  channel | valid   | stall   | word
//  --------+---------+---------+------------------------------
//  in      | i_valid | o_stall | i_operation, i_value
//  out     | o_valid | i_stall | o_status, o_count, o_hash
//
// the cell chain inserts or removes in the accept cycle; in the hash state the xor tree
// over all cells folds the hash into the output register once that register is free
// while a result waits under i_stall the next word is still taken, then held in hash
// until the output register frees up
// i_rst_n is synchronous, active low, and empties the store

module sorted_multiset_with_hash (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic signed [31:0]           i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [4:0]                   o_count,
    output logic signed [31:0]           o_hash
);

    localparam int CAP = smh_pkg::CAPACITY;
    localparam int DW  = smh_pkg::DATA_W;
    localparam int CW  = smh_pkg::CNT_W;

    smh_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    smh_pkg::t_status r_pend_status, n_pend_status;
    logic             r_out_valid, n_out_valid;
    smh_pkg::t_status r_out_status;
    logic [CW-1:0]    r_out_count;
    logic [DW-1:0]    r_out_hash;

    logic             w_in_acc;
    logic             w_full;
    logic             w_found;
    logic             w_load_out;
    logic [DW-1:0]    w_hash;
    smh_pkg::t_cmd    w_cmd;

    logic [DW-1:0]    w_entry [CAP];
    logic [DW-1:0]    w_term  [CAP];
    logic [CAP-1:0]   w_ge;
    logic [CAP-1:0]   w_found_chain;
    logic [CAP-1:0]   w_valid;

    assign o_stall  = (r_state != smh_pkg::S_IDLE);
    assign w_in_acc = i_valid && (r_state == smh_pkg::S_IDLE);
    assign w_full   = (r_count == CW'(CAP));
    assign w_found  = w_found_chain[CAP-1];

    assign w_cmd.op    = smh_pkg::t_op'(i_operation);
    assign w_cmd.value = i_value;
    assign w_cmd.load  = w_in_acc && !((w_cmd.op == smh_pkg::OP_INSERT) && w_full);

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;
        logic          w_left_ge;
        logic          w_found_in;

        assign w_valid[g] = (r_count > CW'(g));

        if (g == 0) begin : g_first
            assign w_left     = w_entry[g];
            assign w_left_ge  = 1'b0;
            assign w_found_in = 1'b0;
        end else begin : g_mid
            assign w_left     = w_entry[g-1];
            assign w_left_ge  = w_ge[g-1];
            assign w_found_in = w_found_chain[g-1];
        end

        if (g == CAP - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        smh_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_index       (smh_pkg::IDX_W'(g)),
            .i_valid       (w_valid[g]),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .i_left_ge     (w_left_ge),
            .i_found_in    (w_found_in),
            .o_entry       (w_entry[g]),
            .o_ge          (w_ge[g]),
            .o_found_out   (w_found_chain[g]),
            .o_term        (w_term[g])
        );
    end

    always_comb begin
        w_hash = '0;
        for (int k = 0; k < CAP; k++) begin
            w_hash = w_hash ^ w_term[k];
        end
    end

    always_comb begin
        n_count       = r_count;
        n_pend_status = r_pend_status;
        if (w_in_acc) begin
            case (w_cmd.op)
                smh_pkg::OP_INSERT: begin
                    if (w_full) begin
                        n_pend_status = smh_pkg::ST_FULL;
                    end else begin
                        n_pend_status = smh_pkg::ST_DONE;
                        n_count       = r_count + CW'(1);
                    end
                end
                smh_pkg::OP_REMOVE: begin
                    if (w_found) begin
                        n_pend_status = smh_pkg::ST_DONE;
                        n_count       = r_count - CW'(1);
                    end else begin
                        n_pend_status = smh_pkg::ST_ABSENT;
                    end
                end
                default: n_pend_status = smh_pkg::ST_DONE;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        w_load_out  = 1'b0;
        case (r_state)
            smh_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = smh_pkg::S_HASH;
                end
            end
            smh_pkg::S_HASH: begin
                if (!r_out_valid || !i_stall) begin
                    n_state     = smh_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    w_load_out  = 1'b1;
                end
            end
            default: n_state = smh_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smh_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        if (w_load_out) begin
            r_out_status <= r_pend_status;
            r_out_count  <= r_count;
            r_out_hash   <= w_hash;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_count  = 5'(r_out_count);
    assign o_hash   = $signed(r_out_hash);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("count above capacity");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_cmd.op == smh_pkg::OP_INSERT) && w_full) |=> $stable(r_count))
        else $error("rejected insert changed the count");

    a_absent_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_cmd.op == smh_pkg::OP_REMOVE) && !w_found) |=> $stable(r_count))
        else $error("remove of absent value changed the count");

    a_accept_to_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == smh_pkg::S_HASH))
        else $error("accepted word did not go to hash");

endmodule

// ----- sim/sorted_multiset_with_hash_test.sv -----
`timescale 1ns / 1ps
// sorted_multiset_with_hash_test: self-checking bench for sorted_multiset_with_hash that
// drives insert/remove words, keeps a shadow sorted set and checks status, count and hash
// depends on smh_pkg and sorted_multiset_with_hash

module sorted_multiset_with_hash_test;

    typedef struct {
        smh_pkg::t_op       op;
        logic signed [31:0] value;
        logic               drain;
    } t_word;

    typedef struct {
        smh_pkg::t_status            status;
        logic [smh_pkg::COUNT_W-1:0] count;
        logic [smh_pkg::DATA_W-1:0]  hash;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_operation = 1'b0;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic [4:0]         o_count;
    logic signed [31:0] o_hash;

    t_word              word_q[$];
    t_result            result_q[$];
    logic signed [31:0] shadow_set[$];
    t_result            want;
    int                 words_sent = 0;
    int                 words_rcvd = 0;
    int                 fail_count = 0;

    sorted_multiset_with_hash u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_hash      (o_hash)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [smh_pkg::DATA_W-1:0] set_hash();
        logic [smh_pkg::DATA_W-1:0] h;
        h = '0;
        for (int i = shadow_set.size() - 1; i >= 0; i--) begin
            h = (h ^ (h << smh_pkg::HASH_SHIFT)) ^ shadow_set[i];
        end
        return h;
    endfunction

    function automatic void update_shadow_set(smh_pkg::t_op op, logic signed [31:0] v);
        t_result r;
        int      pos;
        pos = 0;
        if (op == smh_pkg::OP_INSERT) begin
            if (shadow_set.size() >= smh_pkg::CAPACITY) begin
                r.status = smh_pkg::ST_FULL;
            end else begin
                while (pos < shadow_set.size() && shadow_set[pos] < v) pos++;
                shadow_set.insert(pos, v);
                r.status = smh_pkg::ST_DONE;
            end
        end else begin
            while (pos < shadow_set.size() && shadow_set[pos] != v) pos++;
            if (pos >= shadow_set.size()) begin
                r.status = smh_pkg::ST_ABSENT;
            end else begin
                shadow_set.delete(pos);
                r.status = smh_pkg::ST_DONE;
            end
        end
        r.count = smh_pkg::COUNT_W'(shadow_set.size());
        r.hash  = set_hash();
        result_q.push_back(r);
    endfunction

    function automatic void add_word(smh_pkg::t_op op, logic signed [31:0] v, logic drain);
        t_word w;
        w.op    = op;
        w.value = v;
        w.drain = drain;
        word_q.push_back(w);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                update_shadow_set(smh_pkg::t_op'(i_operation), i_value);
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (word_q.size() != 0 &&
                    !(word_q[0].drain && result_q.size() != 0) &&
                    ((words_sent >= 300 && words_sent < 420) || $urandom_range(99) >= 19)) begin
                    i_valid     <= 1'b1;
                    i_operation <= word_q[0].op;
                    i_value     <= word_q[0].value;
                    void'(word_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (result_q.size() == 0) begin
                    $error("unexpected word: status %0d count %0d hash %h",
                           o_status, o_count, o_hash);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("o_status mismatch: expected %0d actual %0d",
                               want.status, o_status);
                        fail_count++;
                    end
                    if (o_count !== want.count) begin
                        $error("o_count mismatch: expected %0d actual %0d",
                               want.count, o_count);
                        fail_count++;
                    end
                    if (o_hash !== want.hash) begin
                        $error("o_hash mismatch: expected %h actual %h", want.hash, o_hash);
                        fail_count++;
                    end
                end
                words_rcvd++;
            end
            i_stall <= (words_rcvd >= 300 && words_rcvd < 420) ? 1'b0
                                                                : ($urandom_range(99) < 19);
        end
    end

    initial begin
        logic signed [31:0] pool[8];
        int                 bias;
        smh_pkg::t_op       op;
        logic signed [31:0] v;

        // empty store, extremes, duplicates
        add_word(smh_pkg::OP_REMOVE, 32'sd7, 1'b0);
        add_word(smh_pkg::OP_INSERT, 32'sh7fffffff, 1'b0);
        add_word(smh_pkg::OP_INSERT, 32'sh80000000, 1'b0);
        add_word(smh_pkg::OP_INSERT, 32'sd0, 1'b0);
        add_word(smh_pkg::OP_INSERT, -32'sd1, 1'b0);
        add_word(smh_pkg::OP_INSERT, 32'sd0, 1'b0);
        add_word(smh_pkg::OP_REMOVE, 32'sd0, 1'b0);
        add_word(smh_pkg::OP_REMOVE, 32'sh80000000, 1'b0);
        add_word(smh_pkg::OP_REMOVE, 32'sd3, 1'b0);
        // fill up, then overflow
        for (int k = 0; k < 13; k++) begin
            add_word(smh_pkg::OP_INSERT, 32'sd11 - k * 37, 1'b0);
        end
        add_word(smh_pkg::OP_INSERT, 32'sd5, 1'b0);
        add_word(smh_pkg::OP_REMOVE, 32'sh7fffffff, 1'b0);

        for (int n = 0; n < 700; n++) begin
            if (n % 50 == 0) begin
                bias = ((n / 50) % 2 == 0) ? 75 : 35;
                for (int k = 0; k < 8; k++) begin
                    pool[k] = $urandom_range(1) ? $signed($urandom)
                                                : $signed($urandom_range(40)) - 20;
                end
            end
            op = ($urandom_range(99) < bias) ? smh_pkg::OP_INSERT : smh_pkg::OP_REMOVE;
            v  = ($urandom_range(9) < 7) ? pool[$urandom_range(7)] : $signed($urandom);
            add_word(op, v, n == 0 || n == 350);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (word_q.size() != 0 || i_valid || result_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/smh_pkg.sv
rtl/smh_cell.sv
rtl/sorted_multiset_with_hash.sv
sim/sorted_multiset_with_hash_test.sv
